>>> rtl/ibd_pkg.sv
package ibd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 18;
    localparam int SEC_W    = 16;
    localparam int FACTOR_W = 5;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 2;
    localparam int PC_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_BEGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_END   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR   = 2'd3;

    localparam logic [RATE_W-1:0]   RESET_SAMPLE_RATE  = 18'd44100;
    localparam logic [FACTOR_W-1:0] RESET_SPEED_FACTOR = 5'd1;
    localparam logic [SEC_W-1:0]    SEC_MAX            = 16'hFFFF;

    // Datapath operation selected by the control word.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_ACCUM,
        OP_DIV_INIT,
        OP_AVG_OUT,
        OP_PASS,
        OP_ADVANCE
    } t_op;

    // Jump condition; when it is true the sequencer goes to the target step.
    typedef enum logic [2:0] {
        C_NEXT,
        C_JMP,
        C_WAIT_IN,
        C_OUT_BUSY,
        C_OUTSIDE,
        C_NOT_FULL,
        C_DIV_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic             gated;   // operation runs only when the jump is not taken
        logic [PC_W-1:0]  target;
    } t_ctrl;

    localparam logic [PC_W-1:0] STEP_ACCEPT  = 4'd0;
    localparam logic [PC_W-1:0] STEP_BRANCH  = 4'd1;
    localparam logic [PC_W-1:0] STEP_ACCUM   = 4'd2;
    localparam logic [PC_W-1:0] STEP_FULL    = 4'd3;
    localparam logic [PC_W-1:0] STEP_DINIT   = 4'd4;
    localparam logic [PC_W-1:0] STEP_DIV     = 4'd5;
    localparam logic [PC_W-1:0] STEP_AVG_OUT = 4'd6;
    localparam logic [PC_W-1:0] STEP_TO_ADV  = 4'd7;
    localparam logic [PC_W-1:0] STEP_PASS    = 4'd8;
    localparam logic [PC_W-1:0] STEP_ADVANCE = 4'd9;

    function automatic t_ctrl ctrl_rom(input logic [PC_W-1:0] pc);
        t_ctrl w;
        unique case (pc)
            STEP_ACCEPT:  w = '{OP_ACCEPT,   C_WAIT_IN,  1'b1, STEP_ACCEPT};
            STEP_BRANCH:  w = '{OP_NONE,     C_OUTSIDE,  1'b0, STEP_PASS};
            STEP_ACCUM:   w = '{OP_ACCUM,    C_NEXT,     1'b0, STEP_ACCEPT};
            STEP_FULL:    w = '{OP_NONE,     C_NOT_FULL, 1'b0, STEP_ADVANCE};
            STEP_DINIT:   w = '{OP_DIV_INIT, C_NEXT,     1'b0, STEP_ACCEPT};
            STEP_DIV:     w = '{OP_NONE,     C_DIV_BUSY, 1'b0, STEP_DIV};
            STEP_AVG_OUT: w = '{OP_AVG_OUT,  C_OUT_BUSY, 1'b1, STEP_AVG_OUT};
            STEP_TO_ADV:  w = '{OP_NONE,     C_JMP,      1'b0, STEP_ADVANCE};
            STEP_PASS:    w = '{OP_PASS,     C_OUT_BUSY, 1'b1, STEP_PASS};
            STEP_ADVANCE: w = '{OP_ADVANCE,  C_JMP,      1'b0, STEP_ACCEPT};
            default:      w = '{OP_NONE,     C_JMP,      1'b0, STEP_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/ibd_if.sv
interface ibd_in_if;
    import ibd_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    modport source(output valid, output sample_in, input ready);
    modport sink(input valid, input sample_in, output ready);
endinterface

interface ibd_out_if;
    import ibd_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       averaged;
    modport source(output valid, output sample_out, output averaged, input ready);
    modport sink(input valid, input sample_out, input averaged, output ready);
endinterface

>>> rtl/ibd_div.sv
module ibd_div #(
    parameter int WIDTH = 21
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [WIDTH-1:0]              i_dividend,
    input  logic [ibd_pkg::FACTOR_W-1:0]  i_divisor,
    output logic                          o_busy,
    output logic [WIDTH-1:0]              o_quotient
);
    import ibd_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]    r_quo;
    logic [FACTOR_W-1:0] r_rem;
    logic [FACTOR_W-1:0] r_div;
    logic [CNT_W-1:0]    r_cnt;

    logic [FACTOR_W:0]   trial;
    logic [FACTOR_W:0]   diff;
    logic                fits;

    // One restoring step: bring down the next dividend bit and try the subtract.
    assign trial = {r_rem, r_quo[WIDTH-1]};
    assign fits  = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(WIDTH);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[WIDTH-2:0], fits};
            r_rem <= fits ? diff[FACTOR_W-1:0] : trial[FACTOR_W-1:0];
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

endmodule

>>> rtl/interval_boxcar_decimator.sv
// Interval boxcar decimator for a mono 16-bit sample stream.
// Samples enter on i_sample and results leave on o_result, both valid/ready
// channels; a request moves when valid and ready are high at a clock edge.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data),
// to be written only while the block is idle: the user must keep to this, as
// the block itself does not enforce it. A short microprogram steps through
// each sample. A sample that completes a group runs the bit-serial divider,
// one quotient bit a cycle over the group sum width (21 bits at the default
// factor limit), before its averaged result is loaded.
// Samples inside the interval that do not complete a group give no result.
// The result register holds one finished result; while the receiver stalls,
// the next sample is still accepted and worked on, and the sequencer waits
// at its output step until the register is free.
// Synchronous reset restores the register defaults (44100 samples per second,
// empty interval, factor 1) and clears the counters and the partial group.
module interval_boxcar_decimator #(
    parameter int MAX_SPEED_FACTOR = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ibd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ibd_pkg::CFG_W-1:0]      i_cfg_data,
    ibd_in_if.sink                         i_sample,
    ibd_out_if.source                      o_result
);
    import ibd_pkg::*;

    localparam int MAX_CLIP = (MAX_SPEED_FACTOR > 31) ? 31 : MAX_SPEED_FACTOR;
    localparam logic [FACTOR_W-1:0] MAX_F = MAX_CLIP[FACTOR_W-1:0];
    localparam int FILL_W = (MAX_CLIP < 2) ? 1 : $clog2(MAX_CLIP + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_CLIP + 1);

    // Configuration registers.
    logic [RATE_W-1:0]   r_sample_rate;
    logic [SEC_W-1:0]    r_begin;
    logic [SEC_W-1:0]    r_end;
    logic [FACTOR_W-1:0] r_speed;

    // Sequencer and datapath state.
    logic [PC_W-1:0]            r_pc;
    logic [PC_W-1:0]            n_pc;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_inside;
    logic [FACTOR_W-1:0]        r_factor;
    logic [RATE_W-1:0]          r_pos;
    logic [SEC_W-1:0]           r_sec;
    logic signed [SUM_W-1:0]    r_sum;
    logic [FILL_W-1:0]          r_fill;
    logic                       r_neg;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_avg;

    t_ctrl                ctrl;
    logic                 jump;
    logic                 do_op;
    logic                 out_free;
    logic [FACTOR_W-1:0]  eff_factor;
    logic [RATE_W-1:0]    eff_rate;
    logic [RATE_W:0]      pos_inc;
    logic [SUM_W-1:0]     magnitude;
    logic                 div_start;
    logic                 div_busy;
    logic [SUM_W-1:0]     quotient;
    logic [SAMPLE_W-1:0]  avg_sat;

    assign ctrl     = ctrl_rom(r_pc);
    assign out_free = !r_out_valid || o_result.ready;

    always_comb begin
        case (ctrl.cond)
            C_NEXT:     jump = 1'b0;
            C_JMP:      jump = 1'b1;
            C_WAIT_IN:  jump = !i_sample.valid;
            C_OUT_BUSY: jump = !out_free;
            C_OUTSIDE:  jump = !r_inside;
            C_NOT_FULL: jump = 6'(r_fill) < 6'(r_factor);
            C_DIV_BUSY: jump = div_busy;
            default:    jump = 1'b0;
        endcase
        do_op = ctrl.gated ? !jump : 1'b1;
        n_pc  = jump ? ctrl.target : r_pc + 1'b1;
    end

    always_comb begin
        if (r_speed == '0) begin
            eff_factor = FACTOR_W'(1);
        end else if (r_speed > MAX_F) begin
            eff_factor = MAX_F;
        end else begin
            eff_factor = r_speed;
        end
        eff_rate = (r_sample_rate == '0) ? RATE_W'(1) : r_sample_rate;
        pos_inc  = {1'b0, r_pos} + 1'b1;
    end

    assign magnitude = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign div_start = do_op && ctrl.op == OP_DIV_INIT;

    // A lowered factor can leave a quotient beyond 16 bits; clamp it.
    always_comb begin
        if (r_neg) begin
            avg_sat = (quotient > SUM_W'(32768)) ? 16'h8000 : (~quotient[SAMPLE_W-1:0] + 1'b1);
        end else begin
            avg_sat = (quotient > SUM_W'(32767)) ? 16'h7FFF : quotient[SAMPLE_W-1:0];
        end
    end

    ibd_div #(
        .WIDTH(SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (magnitude),
        .i_divisor  (r_factor),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= RESET_SAMPLE_RATE;
            r_begin       <= '0;
            r_end         <= '0;
            r_speed       <= RESET_SPEED_FACTOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SAMPLE_RATE:    r_sample_rate <= i_cfg_data[RATE_W-1:0];
                REG_INTERVAL_BEGIN: r_begin       <= i_cfg_data[SEC_W-1:0];
                REG_INTERVAL_END:   r_end         <= i_cfg_data[SEC_W-1:0];
                REG_SPEED_FACTOR:   r_speed       <= i_cfg_data[FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= STEP_ACCEPT;
            r_pos       <= '0;
            r_sec       <= '0;
            r_sum       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (do_op) begin
                case (ctrl.op)
                    OP_ACCEPT: begin
                        r_sample <= i_sample.sample_in;
                        r_inside <= (r_sec >= r_begin) && (r_sec < r_end);
                        r_factor <= eff_factor;
                    end
                    OP_ACCUM: begin
                        r_sum  <= r_sum + SUM_W'(r_sample);
                        r_fill <= r_fill + 1'b1;
                    end
                    OP_DIV_INIT: begin
                        r_neg  <= r_sum[SUM_W-1];
                        r_sum  <= '0;
                        r_fill <= '0;
                    end
                    OP_AVG_OUT: begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= avg_sat;
                        r_out_avg    <= 1'b1;
                    end
                    OP_PASS: begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_sample;
                        r_out_avg    <= 1'b0;
                        r_sum        <= '0;
                        r_fill       <= '0;
                    end
                    OP_ADVANCE: begin
                        if (pos_inc >= {1'b0, eff_rate}) begin
                            r_pos  <= '0;
                            r_sum  <= '0;
                            r_fill <= '0;
                            if (r_sec != SEC_MAX) begin
                                r_sec <= r_sec + 1'b1;
                            end
                        end else begin
                            r_pos <= pos_inc[RATE_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign i_sample.ready      = ctrl.op == OP_ACCEPT;
    assign o_result.valid      = r_out_valid;
    assign o_result.sample_out = r_out_sample;
    assign o_result.averaged   = r_out_avg;

    // The divider only runs while the sequencer waits on it.
    a_div_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> r_pc == STEP_DIV)
        else $error("divider busy outside its step");

    // The partial group never holds more samples than the largest factor.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        6'(r_fill) <= 6'(MAX_F))
        else $error("group fill beyond factor limit");

    // A pass-through load leaves a valid, non-averaged result.
    a_pass_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_op && ctrl.op == OP_PASS) |=> (r_out_valid && !r_out_avg))
        else $error("pass-through result not loaded");

    // A result is only ever loaded into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_op && (ctrl.op == OP_PASS || ctrl.op == OP_AVG_OUT)) |-> out_free)
        else $error("result register overwritten");

endmodule
